FILE: rtl/transposition_table_probe_record_macros.svh
// Assertion macros for the transposition table block.
// Both expect clk_i in the scope where they are used; TTPR_ASSERT also expects rst_ni.
`ifndef TRANSPOSITION_TABLE_PROBE_RECORD_MACROS_SVH
`define TRANSPOSITION_TABLE_PROBE_RECORD_MACROS_SVH

`ifndef SYNTHESIS

`define TTPR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

`define TTPR_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");

`else

`define TTPR_ASSERT(name, prop)

`define TTPR_ASSERT_RST(name, prop)

`endif

`endif

FILE: rtl/ttpr_pkg.sv
package ttpr_pkg;

  localparam logic FUNC_PROBE  = 1'b0;
  localparam logic FUNC_RECORD = 1'b1;

  typedef enum logic [1:0] {
    BOUND_UNKNOWN = 2'd0,
    BOUND_EXACT   = 2'd1,
    BOUND_UPPER   = 2'd2,
    BOUND_LOWER   = 2'd3
  } bound_e;

  typedef struct packed {
    logic [63:0]        key;
    logic [3:0]         depth;
    logic signed [31:0] score;
    logic [7:0]         move;
    bound_e             bound;
  } entry_t;

  typedef struct packed {
    logic               func;
    logic [63:0]        key;
    logic [3:0]         depth;
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic signed [31:0] score;
    logic [7:0]         move;
    logic [1:0]         bound_kind;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] result_score;
    logic [7:0]         stored_move;
    logic               written;
  } out_word_t;

  typedef struct packed {
    logic clr_en;
    logic load_in;
    logic eval_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_stall;
  } dp_status_t;

endpackage

FILE: rtl/ttpr_if.sv
interface ttpr_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [63:0]        key;
  logic [3:0]         depth;
  logic signed [31:0] alpha;
  logic signed [31:0] beta;
  logic signed [31:0] score;
  logic [7:0]         move;
  logic [1:0]         bound_kind;

  modport source (
    output valid, func, key, depth, alpha, beta, score, move, bound_kind,
    input  ready
  );
  modport sink (
    input  valid, func, key, depth, alpha, beta, score, move, bound_kind,
    output ready
  );
endinterface

interface ttpr_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] result_score;
  logic [7:0]         stored_move;
  logic               written;

  modport source (
    output valid, hit, result_score, stored_move, written,
    input  ready
  );
  modport sink (
    input  valid, hit, result_score, stored_move, written,
    output ready
  );
endinterface

FILE: rtl/ttpr_ctrl.sv
module ttpr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ttpr_pkg::dp_status_t   stat_i,
  output ttpr_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // Hold the read entry until the output register can take the word.
        if (!stat_i.out_stall) begin
          cmd_o.eval_en = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/ttpr_dp.sv
module ttpr_dp #(
  parameter int unsigned IndexBits = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ttpr_pkg::ctrl_cmd_t   cmd_i,
  output ttpr_pkg::dp_status_t  stat_o,
  input  ttpr_pkg::in_word_t    in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ttpr_pkg::out_word_t   out_word_o
);

  localparam int unsigned Depth = 1 << IndexBits;

  ttpr_pkg::entry_t    mem_q [Depth];
  ttpr_pkg::entry_t    rd_q;
  ttpr_pkg::in_word_t  in_q;
  ttpr_pkg::out_word_t out_q, out_d;
  ttpr_pkg::entry_t    wr_entry;
  logic [IndexBits-1:0] clr_addr_q;
  logic [IndexBits-1:0] wr_idx;
  logic                 out_valid_q;
  logic                 replace;
  logic                 key_match;
  logic                 depth_ok;

  assign wr_idx = in_q.key[IndexBits-1:0];

  assign key_match = (rd_q.key == in_q.key);
  assign depth_ok  = (rd_q.depth >= in_q.depth);
  // A known entry that is strictly deeper survives a record.
  assign replace   = !((rd_q.bound != ttpr_pkg::BOUND_UNKNOWN) &&
                       (rd_q.depth > in_q.depth));

  always_comb begin
    wr_entry.key   = in_q.key;
    wr_entry.depth = in_q.depth;
    wr_entry.score = in_q.score;
    wr_entry.move  = in_q.move;
    wr_entry.bound = ttpr_pkg::bound_e'(in_q.bound_kind);
  end

  always_comb begin
    out_d              = '0;
    out_d.stored_move  = rd_q.move;
    if (in_q.func == ttpr_pkg::FUNC_RECORD) begin
      out_d.written = replace;
    end else if (key_match && depth_ok) begin
      case (rd_q.bound)
        ttpr_pkg::BOUND_EXACT: begin
          out_d.hit          = 1'b1;
          out_d.result_score = rd_q.score;
        end
        ttpr_pkg::BOUND_UPPER: begin
          if (rd_q.score <= in_q.alpha) begin
            out_d.hit          = 1'b1;
            out_d.result_score = in_q.alpha;
          end
        end
        ttpr_pkg::BOUND_LOWER: begin
          if (rd_q.score >= in_q.beta) begin
            out_d.hit          = 1'b1;
            out_d.result_score = in_q.beta;
          end
        end
        default: begin
          out_d.hit = 1'b0;
        end
      endcase
    end
  end

  // Table memory: the clearing pass and record writes share the one write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem_q[clr_addr_q] <= '0;
    end else if (cmd_i.eval_en && (in_q.func == ttpr_pkg::FUNC_RECORD) && replace) begin
      mem_q[wr_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      rd_q <= mem_q[in_word_i.key[IndexBits-1:0]];
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.eval_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.clr_last  = &clr_addr_q;
  assign stat_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_word_o       = out_q;

endmodule

FILE: rtl/transposition_table_probe_record.sv
// An accepted word is registered together with the table entry it reads; its result
// word is registered into the output register once that register is free.
// The block takes no new word until the last one is evaluated; the table
// memory is read at accept and written when the word is evaluated.
// A result word waiting in the output register does not block the next accept.
// Reset: a clearing pass writes every one of the 2^INDEX_BITS entries (4096 by default)
// to zero, with input ready held low.
`include "transposition_table_probe_record_macros.svh"

module transposition_table_probe_record #(
  parameter int unsigned INDEX_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttpr_in_if.sink      in_i,
  ttpr_out_if.source   out_o
);

  ttpr_pkg::ctrl_cmd_t  cmd;
  ttpr_pkg::dp_status_t stat;
  ttpr_pkg::in_word_t   in_word;
  ttpr_pkg::out_word_t  out_word;
  logic                 in_ready;
  logic                 out_valid;

  always_comb begin
    in_word.func       = in_i.func;
    in_word.key        = in_i.key;
    in_word.depth      = in_i.depth;
    in_word.alpha      = in_i.alpha;
    in_word.beta       = in_i.beta;
    in_word.score      = in_i.score;
    in_word.move       = in_i.move;
    in_word.bound_kind = in_i.bound_kind;
  end

  ttpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ttpr_dp #(
    .IndexBits (INDEX_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid;
  assign out_o.hit          = out_word.hit;
  assign out_o.result_score = out_word.result_score;
  assign out_o.stored_move  = out_word.stored_move;
  assign out_o.written      = out_word.written;

  `TTPR_ASSERT(a_cmd_onehot, $onehot0({cmd.clr_en, cmd.load_in, cmd.eval_en}))
  `TTPR_ASSERT(a_no_accept_in_clear, cmd.clr_en |-> !in_i.ready)
  `TTPR_ASSERT(a_valid_from_eval, $rose(out_o.valid) |-> $past(cmd.eval_en))
  `TTPR_ASSERT(a_record_no_hit, (out_o.valid && out_o.written) |-> !out_o.hit)
  `TTPR_ASSERT(a_eval_after_load, cmd.eval_en |-> !$past(cmd.clr_en))

endmodule

FILE: tb/ttpr_lookup_monitor.sv
`timescale 1ns / 1ps

module ttpr_lookup_monitor
  import ttpr_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttpr_in_if          word_in_i,
  ttpr_out_if         word_out_i,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned hit_count_o,
  output int unsigned write_count_o
);

  localparam int unsigned ENTRIES = 1 << INDEX_BITS;

  entry_t      tt_shadow [ENTRIES];
  out_word_t   expected_q [$];
  int unsigned err_count;
  int unsigned results_seen;

  assign err_count_o = err_count;

  task automatic report_mismatch(input string what, input longint expv, input longint gotv);
    $display("%t result %0d: %s, expected %0d, got %0d", $time, results_seen, what, expv, gotv);
    err_count++;
  endtask

  // Works out the result of one word and applies its effect on the shadow table.
  function automatic out_word_t probe_or_record(input in_word_t w);
    logic [INDEX_BITS-1:0] idx;
    entry_t                e;
    out_word_t             r;
    idx = w.key[INDEX_BITS-1:0];
    e = tt_shadow[idx];
    r = '0;
    r.stored_move = e.move;
    if (w.func == FUNC_PROBE) begin
      if (e.key == w.key && e.depth >= w.depth) begin
        case (e.bound)
          BOUND_EXACT: begin
            r.hit = 1'b1;
            r.result_score = e.score;
          end
          BOUND_UPPER: begin
            if ($signed(e.score) <= $signed(w.alpha)) begin
              r.hit = 1'b1;
              r.result_score = w.alpha;
            end
          end
          BOUND_LOWER: begin
            if ($signed(e.score) >= $signed(w.beta)) begin
              r.hit = 1'b1;
              r.result_score = w.beta;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (!(e.bound != BOUND_UNKNOWN && e.depth > w.depth)) begin
      e.key   = w.key;
      e.depth = w.depth;
      e.score = w.score;
      e.move  = w.move;
      e.bound = bound_e'(w.bound_kind);
      tt_shadow[idx] = e;
      r.written = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_word_t  w;
    out_word_t got;
    out_word_t exp_word;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tt_shadow[i] = '0;
      end
      expected_q.delete();
      err_count = 0;
      results_seen = 0;
      pending_o <= 0;
      hit_count_o <= 0;
      write_count_o <= 0;
    end else begin
      // Results are taken before the new word is queued; the queue keeps order anyway.
      if (word_out_i.valid && word_out_i.ready) begin
        got.hit          = word_out_i.hit;
        got.result_score = word_out_i.result_score;
        got.stored_move  = word_out_i.stored_move;
        got.written      = word_out_i.written;
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding", 0, 0);
        end else begin
          exp_word = expected_q.pop_front();
          if (got.hit !== exp_word.hit)
            report_mismatch("hit", exp_word.hit, got.hit);
          if (got.result_score !== exp_word.result_score)
            report_mismatch("result_score", longint'($signed(exp_word.result_score)),
                            longint'($signed(got.result_score)));
          if (got.stored_move !== exp_word.stored_move)
            report_mismatch("stored_move", exp_word.stored_move, got.stored_move);
          if (got.written !== exp_word.written)
            report_mismatch("written", exp_word.written, got.written);
          if (exp_word.hit)
            hit_count_o <= hit_count_o + 1;
          if (exp_word.written)
            write_count_o <= write_count_o + 1;
        end
        results_seen++;
      end
      if (word_in_i.valid && word_in_i.ready) begin
        w.func       = word_in_i.func;
        w.key        = word_in_i.key;
        w.depth      = word_in_i.depth;
        w.alpha      = word_in_i.alpha;
        w.beta       = word_in_i.beta;
        w.score      = word_in_i.score;
        w.move       = word_in_i.move;
        w.bound_kind = word_in_i.bound_kind;
        expected_q.push_back(probe_or_record(w));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: tb/transposition_table_probe_record_tb.sv
`timescale 1ns / 1ps

module transposition_table_probe_record_tb;
  import ttpr_pkg::*;

  localparam int unsigned TT_INDEX_BITS = 12;
  localparam int unsigned RANDOM_WORDS  = 800;
  localparam int unsigned POOL_SIZE     = 24;
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        steady;
  int unsigned words_sent;
  int unsigned err_count;
  int unsigned pending;
  int unsigned hit_count;
  int unsigned write_count;
  logic [63:0] key_pool [POOL_SIZE];

  ttpr_in_if  in_bus ();
  ttpr_out_if out_bus ();

  transposition_table_probe_record #(
    .INDEX_BITS(TT_INDEX_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  ttpr_lookup_monitor #(
    .INDEX_BITS(TT_INDEX_BITS)
  ) u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_in_i    (in_bus),
    .word_out_i   (out_bus),
    .err_count_o  (err_count),
    .pending_o    (pending),
    .hit_count_o  (hit_count),
    .write_count_o(write_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d result words outstanding", pending);
    $display("transposition_table_probe_record_tb: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    out_bus.ready <= steady || ($urandom_range(0, 99) >= 6);
  end

  task automatic send_word(input in_word_t w);
    while (!steady && $urandom_range(0, 99) < 6) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= w.func;
    in_bus.key        <= w.key;
    in_bus.depth      <= w.depth;
    in_bus.alpha      <= w.alpha;
    in_bus.beta       <= w.beta;
    in_bus.score      <= w.score;
    in_bus.move       <= w.move;
    in_bus.bound_kind <= w.bound_kind;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // The ignored fields of a probe still carry random bits.
  task automatic probe(input logic [63:0] key, input logic [3:0] depth,
                       input logic signed [31:0] alpha, input logic signed [31:0] beta);
    in_word_t w;
    w.func       = FUNC_PROBE;
    w.key        = key;
    w.depth      = depth;
    w.alpha      = alpha;
    w.beta       = beta;
    w.score      = $urandom;
    w.move       = 8'($urandom);
    w.bound_kind = 2'($urandom_range(0, 3));
    send_word(w);
  endtask

  task automatic record(input logic [63:0] key, input logic [3:0] depth,
                        input logic signed [31:0] score, input logic [7:0] move,
                        input bound_e kind);
    in_word_t w;
    w.func       = FUNC_RECORD;
    w.key        = key;
    w.depth      = depth;
    w.alpha      = $urandom;
    w.beta       = $urandom;
    w.score      = score;
    w.move       = move;
    w.bound_kind = kind;
    send_word(w);
  endtask

  // Scores cluster around a few values so that bound comparisons often succeed.
  function automatic logic signed [31:0] pick_score();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $signed($urandom_range(0, 6)) - 32'sd3;
    if (roll < 80) return INT_MAX;
    if (roll < 90) return INT_MIN;
    return $urandom;
  endfunction

  initial begin
    logic [63:0] k1;
    logic [63:0] k1_alias;
    logic [63:0] k;
    logic [11:0] slots [8];
    in_word_t    w;
    int unsigned roll;

    rst_ni            = 1'b0;
    steady            = 1'b0;
    words_sent        = 0;
    in_bus.valid      = 1'b0;
    in_bus.func       = FUNC_PROBE;
    in_bus.key        = '0;
    in_bus.depth      = '0;
    in_bus.alpha      = '0;
    in_bus.beta       = '0;
    in_bus.score      = '0;
    in_bus.move       = '0;
    in_bus.bound_kind = '0;
    out_bus.ready     = 1'b0;

    slots = '{12'h000, 12'hFFF, 12'h001, 12'h800, 12'h555, 12'hAAA, 12'h007, 12'h123};
    // Three keys share each index, so replacement and key mismatches are common.
    for (int i = 0; i < POOL_SIZE; i++) begin
      k = {$urandom, $urandom};
      k[11:0] = slots[i / 3];
      key_pool[i] = k;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    k1       = 64'hA5A5_0000_1234_5123;
    k1_alias = k1 ^ 64'h8000_0000_0000_0000;

    // A fresh entry matches key zero but its flag is unknown.
    probe(64'd0, 4'd0, INT_MIN, INT_MAX);
    record(64'd0, 4'd0, INT_MAX, 8'hFF, BOUND_UNKNOWN);
    probe(64'd0, 4'd0, INT_MIN, INT_MAX);
    record(64'd0, 4'd15, INT_MIN, 8'h00, BOUND_EXACT);
    probe(64'd0, 4'd15, INT_MAX, INT_MIN);
    record(k1, 4'd5, INT_MAX, 8'h5A, BOUND_EXACT);
    probe(k1, 4'd5, 32'sd0, 32'sd0);
    probe(k1, 4'd6, 32'sd0, 32'sd0);
    record(k1, 4'd3, 32'sd7, 8'h01, BOUND_EXACT);
    record(k1, 4'd5, -32'sd100, 8'h11, BOUND_UPPER);
    probe(k1, 4'd0, -32'sd100, INT_MAX);
    probe(k1, 4'd0, -32'sd101, INT_MAX);
    record(k1, 4'd15, INT_MAX, 8'h22, BOUND_LOWER);
    probe(k1, 4'd15, 32'sd0, INT_MAX);
    probe(k1, 4'd15, 32'sd0, INT_MIN);
    probe(k1_alias, 4'd0, INT_MAX, INT_MIN);
    record(k1_alias, 4'd14, 32'sd1, 8'h2B, BOUND_EXACT);
    record(k1_alias, 4'd15, INT_MIN, 8'h33, BOUND_UPPER);
    probe(k1_alias, 4'd7, INT_MAX, 32'sd0);
    probe(k1_alias, 4'd7, INT_MIN, 32'sd0);
    probe(k1, 4'd0, INT_MAX, INT_MIN);
    record(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'sd0, 8'hFF, BOUND_LOWER);
    probe(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, INT_MAX, INT_MIN);
    probe(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, INT_MIN, 32'sd1);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= 350 && n < 550);
      roll = $urandom_range(0, 99);
      w.func       = ($urandom_range(0, 99) < 45) ? FUNC_RECORD : FUNC_PROBE;
      w.key        = {$urandom, $urandom};
      w.depth      = 4'($urandom_range(0, 15));
      w.alpha      = $urandom;
      w.beta       = $urandom;
      w.score      = $urandom;
      w.move       = 8'($urandom);
      w.bound_kind = 2'($urandom_range(0, 3));
      if (roll >= 15) begin
        w.key   = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        w.score = pick_score();
        w.alpha = pick_score();
        w.beta  = pick_score();
        if (w.func == FUNC_PROBE && $urandom_range(0, 1) == 1)
          w.depth = 4'($urandom_range(0, 4));
      end
      send_word(w);
    end
    steady = 1'b0;
    in_bus.valid <= 1'b0;

    // The outstanding count is a registered output of the monitor.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d words sent, %0d probes hit, %0d records replaced an entry",
             words_sent, hit_count, write_count);
    if (err_count == 0) begin
      $display("transposition_table_probe_record_tb: clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("transposition_table_probe_record_tb: errors");
    end
    $finish;
  end

endmodule
